### hdl/winograd_filter_transform_f4x4_3x3_top_defines.svh
// Assertion macros for the Winograd filter transform block.
`ifndef WINOGRAD_FILTER_TRANSFORM_F4X4_3X3_TOP_DEFINES_SVH
`define WINOGRAD_FILTER_TRANSFORM_F4X4_3X3_TOP_DEFINES_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset
`define WFT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset
`define WFT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/wft_pkg.sv
// Shared types, constants and transform coefficients of the filter transform block.
package wft_pkg;

    // Field widths
    localparam int W_W       = 16;
    localparam int IDX_W     = 10;
    localparam int CNT_W     = 11;
    localparam int COEFF_W   = 18;
    localparam int ADDR_W    = 26;
    localparam int BASE_W    = 21;
    localparam int STRIDE_W  = 22;
    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 48;

    // Clamp limits of the count registers
    localparam int MAX_FILTERS  = 1024;
    localparam int MAX_CHANNELS = 1024;

    // Tile geometry
    localparam int TILE    = 6;
    localparam int TAPS    = 3;
    localparam int NW      = TAPS * TAPS;
    localparam int TIDX_W  = $clog2(TILE);
    localparam int GIDX_W  = $clog2(TILE * TAPS);

    // Datapath widths: G is Q1.16 (needs 18 bits for +1.0)
    localparam int G_W     = 18;
    localparam int PROD1_W = G_W + W_W;
    localparam int T_W     = PROD1_W;
    localparam int PROD3_W = T_W + G_W;
    localparam int RND_SH  = 32;
    localparam int QW      = PROD3_W - RND_SH;

    // Job queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int QAW     = $clog2(Q_DEPTH);

    // Configuration register indexes
    localparam logic [0:0] REG_NUM_FILTERS  = 1'd0;
    localparam logic [0:0] REG_NUM_CHANNELS = 1'd1;

    // Interpolation matrix G, 6 rows of 3, row-major
    localparam logic signed [G_W-1:0] G_TAB [TILE*TAPS] = '{
         18'sd65536,       18'sd0,       18'sd0,
        -18'sd43691,  -18'sd30894,  -18'sd21845,
        -18'sd43691,   18'sd30894,  -18'sd21845,
         18'sd10923,   18'sd15447,   18'sd21845,
         18'sd10923,  -18'sd15447,   18'sd21845,
         18'sd0,           18'sd0,   18'sd65536
    };

    // One classified filter waiting for the transform datapath
    typedef struct packed {
        logic [NW-1:0][W_W-1:0] w;
        logic                   err;
        logic [BASE_W-1:0]      base;
        logic [STRIDE_W-1:0]    stride;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } q_entry_t;

endpackage

### hdl/wft_front.sv
// Front end: accepts a filter transfer, checks its indexes and works out its address terms.
module wft_front #(
    parameter int MAX_FILTERS  = wft_pkg::MAX_FILTERS,
    parameter int MAX_CHANNELS = wft_pkg::MAX_CHANNELS
) (
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata: w00, w01, w02, w10, w11, w12, w20, w21, w22, filter_index, channel_index
    input  logic [wft_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic [wft_pkg::CNT_W-1:0]          num_filters,
    input  logic [wft_pkg::CNT_W-1:0]          num_channels,
    input  logic                               q_full,
    output wft_pkg::q_entry_t                  push
);

    logic [wft_pkg::IDX_W-1:0] fi;
    logic [wft_pkg::IDX_W-1:0] ci;
    logic [wft_pkg::CNT_W-1:0] nf;
    logic [wft_pkg::CNT_W-1:0] nc;

    // Field unpacking
    assign fi = s_tdata[wft_pkg::NW*wft_pkg::W_W +: wft_pkg::IDX_W];
    assign ci = s_tdata[wft_pkg::NW*wft_pkg::W_W + wft_pkg::IDX_W +: wft_pkg::IDX_W];

    // Counts clamped to their limits
    assign nf = (32'(num_filters) > MAX_FILTERS)
                ? wft_pkg::CNT_W'(MAX_FILTERS) : num_filters;
    assign nc = (32'(num_channels) > MAX_CHANNELS)
                ? wft_pkg::CNT_W'(MAX_CHANNELS) : num_channels;

    assign s_tready = !q_full;

    // Classify and build the queue entry
    always_comb
    begin
        push.valid      = s_tvalid && !q_full;
        push.job.w      = s_tdata[wft_pkg::NW*wft_pkg::W_W-1:0];
        push.job.err    = ({1'b0, fi} >= nf) || ({1'b0, ci} >= nc);
        push.job.base   = {{(wft_pkg::BASE_W-wft_pkg::IDX_W){1'b0}}, ci}
                        * {{(wft_pkg::BASE_W-wft_pkg::CNT_W){1'b0}}, nf}
                        + {{(wft_pkg::BASE_W-wft_pkg::IDX_W){1'b0}}, fi};
        push.job.stride = {{(wft_pkg::STRIDE_W-wft_pkg::CNT_W){1'b0}}, nf}
                        * {{(wft_pkg::STRIDE_W-wft_pkg::CNT_W){1'b0}}, nc};
    end

endmodule

### hdl/wft_queue.sv
// Short job queue between the front end and the transform datapath.
module wft_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  wft_pkg::q_entry_t push,
    output logic              full,
    output wft_pkg::q_entry_t head,
    input  logic              pop
);

    // Depth is a power of two, so the pointers wrap on their own
    wft_pkg::job_t             mem_reg [wft_pkg::Q_DEPTH];
    logic [wft_pkg::QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [wft_pkg::QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [wft_pkg::QAW:0]     count_reg, count_next;
    logic                      do_push;
    logic                      do_pop;

    assign full    = (count_reg == (wft_pkg::QAW+1)'(wft_pkg::Q_DEPTH));
    assign do_push = push.valid && !full;
    assign do_pop  = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.job   = mem_reg[rd_ptr_reg];

    // Pointer and fill level
    always_comb
    begin
        wr_ptr_next = do_push ? wft_pkg::QAW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? wft_pkg::QAW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.job;
        end
    end

endmodule

### hdl/wft_back.sv
// Back end: walks the 6x6 tile of the head job and streams the transformed coefficients.
module wft_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  wft_pkg::q_entry_t                  head,
    output logic                               pop,
    output logic                               at_last,
    input  logic                               m_tready,
    output logic                               m_tvalid,
    // m_tdata: coeff, dest_address
    output logic [wft_pkg::OUT_DATA_W-1:0]     m_tdata,
    // m_tuser: index_error
    output logic                               m_tuser,
    output logic                               m_tlast
);

    localparam int TW = wft_pkg::TIDX_W;
    localparam int GW = wft_pkg::GIDX_W;

    // Position sequencer
    logic [TW-1:0]              i_reg, i_next;
    logic [TW-1:0]              j_reg, j_next;
    logic [wft_pkg::ADDR_W-1:0] off_reg, off_next;
    logic                       en;
    logic                       issue;

    // Stage 1: G row times weights
    logic                                 v1_reg;
    logic signed [wft_pkg::PROD1_W-1:0]   prod1_reg [wft_pkg::NW];
    logic signed [wft_pkg::PROD1_W-1:0]   prod1_next [wft_pkg::NW];
    logic [TW-1:0]                        j1_reg;
    logic [wft_pkg::ADDR_W-1:0]           addr1_reg, addr1_next;
    logic                                 err1_reg, last1_reg;

    // Stage 2: one row of T = G f
    logic                                 v2_reg;
    logic signed [wft_pkg::T_W-1:0]       t_reg [wft_pkg::TAPS];
    logic signed [wft_pkg::T_W-1:0]       t_next [wft_pkg::TAPS];
    logic [TW-1:0]                        j2_reg;
    logic [wft_pkg::ADDR_W-1:0]           addr2_reg;
    logic                                 err2_reg, last2_reg;

    // Stage 3: T row times G row
    logic                                 v3_reg;
    logic signed [wft_pkg::PROD3_W-1:0]   prod3_reg [wft_pkg::TAPS];
    logic signed [wft_pkg::PROD3_W-1:0]   prod3_next [wft_pkg::TAPS];
    logic [wft_pkg::ADDR_W-1:0]           addr3_reg;
    logic                                 err3_reg, last3_reg;

    // Stage 4: output register
    logic                                 v4_reg;
    logic [wft_pkg::COEFF_W-1:0]          coeff_reg, coeff_next;
    logic [wft_pkg::ADDR_W-1:0]           addr4_reg;
    logic                                 err4_reg, last4_reg;

    logic signed [wft_pkg::PROD3_W-1:0]   usum;
    logic signed [wft_pkg::PROD3_W-1:0]   ubias;
    logic signed [wft_pkg::QW-1:0]        q;

    // Whole pipeline moves unless the output is held
    assign en      = !v4_reg || m_tready;
    assign issue   = en && head.valid;
    assign at_last = (i_reg == TW'(wft_pkg::TILE-1)) && (j_reg == TW'(wft_pkg::TILE-1));
    assign pop     = issue && at_last;

    // Sequencer: row-major walk, address offset grows by one stride per position
    always_comb
    begin
        i_next   = i_reg;
        j_next   = j_reg;
        off_next = off_reg;
        if (issue)
        begin
            if (at_last)
            begin
                i_next   = '0;
                j_next   = '0;
                off_next = '0;
            end
            else
            begin
                off_next = off_reg + {{(wft_pkg::ADDR_W-wft_pkg::STRIDE_W){1'b0}},
                                      head.job.stride};
                if (j_reg == TW'(wft_pkg::TILE-1))
                begin
                    j_next = '0;
                    i_next = i_reg + 1'b1;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
        end
    end

    // Stage 1 products
    always_comb
    begin
        for (int l = 0; l < wft_pkg::TAPS; l++)
        begin
            for (int c = 0; c < wft_pkg::TAPS; c++)
            begin
                prod1_next[l*wft_pkg::TAPS+c] =
                    wft_pkg::G_TAB[GW'(i_reg) * GW'(wft_pkg::TAPS) + GW'(l)]
                    * $signed(head.job.w[l*wft_pkg::TAPS+c]);
            end
        end
        addr1_next = head.job.err ? '0
                   : {{(wft_pkg::ADDR_W-wft_pkg::BASE_W){1'b0}}, head.job.base} + off_reg;
    end

    // Stage 2 column sums
    always_comb
    begin
        for (int c = 0; c < wft_pkg::TAPS; c++)
        begin
            t_next[c] = prod1_reg[c] + prod1_reg[wft_pkg::TAPS+c]
                      + prod1_reg[2*wft_pkg::TAPS+c];
        end
    end

    // Stage 3 products
    always_comb
    begin
        for (int c = 0; c < wft_pkg::TAPS; c++)
        begin
            prod3_next[c] = t_reg[c] * wft_pkg::G_TAB[GW'(j2_reg) * GW'(wft_pkg::TAPS) + GW'(c)];
        end
    end

    // Stage 4: sum, round half up, saturate
    always_comb
    begin
        usum  = prod3_reg[0] + prod3_reg[1] + prod3_reg[2];
        ubias = usum + (wft_pkg::PROD3_W'(1) <<< (wft_pkg::RND_SH-1));
        q     = wft_pkg::QW'(ubias >>> wft_pkg::RND_SH);
        if (q > wft_pkg::QW'(131071))
        begin
            coeff_next = 18'h1FFFF;
        end
        else if (q < -(wft_pkg::QW'(131072)))
        begin
            coeff_next = 18'h20000;
        end
        else
        begin
            coeff_next = q[wft_pkg::COEFF_W-1:0];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg   <= '0;
            j_reg   <= '0;
            off_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
        end
        else
        begin
            i_reg   <= i_next;
            j_reg   <= j_next;
            off_reg <= off_next;
            if (en)
            begin
                v1_reg <= head.valid;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod1_reg <= prod1_next;
            j1_reg    <= j_reg;
            addr1_reg <= addr1_next;
            err1_reg  <= head.job.err;
            last1_reg <= at_last;

            t_reg     <= t_next;
            j2_reg    <= j1_reg;
            addr2_reg <= addr1_reg;
            err2_reg  <= err1_reg;
            last2_reg <= last1_reg;

            prod3_reg <= prod3_next;
            addr3_reg <= addr2_reg;
            err3_reg  <= err2_reg;
            last3_reg <= last2_reg;

            coeff_reg <= coeff_next;
            addr4_reg <= addr3_reg;
            err4_reg  <= err3_reg;
            last4_reg <= last3_reg;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {{(wft_pkg::OUT_DATA_W-wft_pkg::ADDR_W-wft_pkg::COEFF_W){1'b0}},
                       addr4_reg, coeff_reg};
    assign m_tuser  = err4_reg;
    assign m_tlast  = last4_reg;

endmodule

### hdl/winograd_filter_transform_f4x4_3x3_top.sv
// Winograd F(4x4,3x3) filter transform, top level with configuration registers.
// Each accepted transfer carries one 3x3 filter (Q3.12) with its filter and channel
// index; the block answers with 36 transfers of the 6x6 tile G*f*G^T in row-major
// order, each a Q5.12 coefficient with its address in the transposed weight layout
// and tlast on the 36th. The transform datapath produces one coefficient per cycle
// while the output is not held, and the input side takes the next filter straight
// away into a two-entry job queue while the queue has room. When the datapath is
// free, the first coefficient follows the input transfer through the job queue and
// the pipeline stages. tuser flags an index not below its count; such coefficients
// carry address zero. Counts above MAX_FILTERS and MAX_CHANNELS (1024 by default)
// are clamped to those limits. Write configuration only while the block is idle.
`include "winograd_filter_transform_f4x4_3x3_top_defines.svh"

module winograd_filter_transform_f4x4_3x3_top #(
    parameter int MAX_FILTERS  = wft_pkg::MAX_FILTERS,
    parameter int MAX_CHANNELS = wft_pkg::MAX_CHANNELS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write port
    input  logic                               cfg_we,
    input  logic [0:0]                         cfg_index,
    input  logic [wft_pkg::CNT_W-1:0]          cfg_data,
    // Filter input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata: w00, w01, w02, w10, w11, w12, w20, w21, w22, filter_index, channel_index
    input  logic [wft_pkg::IN_DATA_W-1:0]      s_tdata,
    // Coefficient output stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata: coeff, dest_address
    output logic [wft_pkg::OUT_DATA_W-1:0]     m_tdata,
    // m_tuser: index_error
    output logic                               m_tuser,
    output logic                               m_tlast
);

    logic [wft_pkg::CNT_W-1:0] num_filters_reg, num_filters_next;
    logic [wft_pkg::CNT_W-1:0] num_channels_reg, num_channels_next;
    wft_pkg::q_entry_t         push;
    wft_pkg::q_entry_t         head;
    logic                      q_full;
    logic                      q_pop;
    logic                      at_last;
    logic                      cfg_nf_we;

    // Configuration registers
    always_comb
    begin
        num_filters_next  = num_filters_reg;
        num_channels_next = num_channels_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                wft_pkg::REG_NUM_FILTERS:  num_filters_next  = cfg_data;
                wft_pkg::REG_NUM_CHANNELS: num_channels_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_filters_reg  <= wft_pkg::CNT_W'(1);
            num_channels_reg <= wft_pkg::CNT_W'(1);
        end
        else
        begin
            num_filters_reg  <= num_filters_next;
            num_channels_reg <= num_channels_next;
        end
    end

    wft_front #(
        .MAX_FILTERS  (MAX_FILTERS),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .num_filters  (num_filters_reg),
        .num_channels (num_channels_reg),
        .q_full       (q_full),
        .push         (push)
    );

    wft_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .head  (head),
        .pop   (q_pop)
    );

    wft_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (q_pop),
        .at_last  (at_last),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Checks
    assign cfg_nf_we = cfg_we && (cfg_index == wft_pkg::REG_NUM_FILTERS);

    `WFT_ASSERT_NOW(a_err_addr_zero, m_tvalid && m_tuser, m_tdata[43:18] == '0, "addr not zero")
    `WFT_ASSERT_NOW(a_pop_at_tile_end, q_pop, head.valid && at_last, "job retired early")
    `WFT_ASSERT_NEXT(a_cfg_filters, cfg_nf_we, num_filters_reg == $past(cfg_data), "count lost")

endmodule

### tb/wft_coeff_checker.sv
// Checker for the Winograd filter transform: mirrors the counts, predicts each tile, compares.
module wft_coeff_checker
    import wft_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [0:0]            cfg_index,
    input  logic [CNT_W-1:0]      cfg_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // s_tdata: w00, w01, w02, w10, w11, w12, w20, w21, w22, filter_index, channel_index
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata: coeff, dest_address
    input  logic [OUT_DATA_W-1:0] m_tdata,
    // m_tuser: index_error
    input  logic                  m_tuser,
    input  logic                  m_tlast,
    output int                    mismatches,
    output int                    pending,
    output int                    filters_seen,
    output int                    coeffs_seen
);

    // One expected coefficient transfer
    typedef struct packed {
        logic [5:0]         pos;
        logic [COEFF_W-1:0] coeff;
        logic [ADDR_W-1:0]  addr;
        logic               err;
        logic               last;
    } coeff_rec_t;

    // Interpolation matrix G in Q1.16, 6 rows of 3
    localparam longint GQ [18] = '{
        65536,      0,      0,
        -43691, -30894, -21845,
        -43691,  30894, -21845,
        10923,   15447,  21845,
        10923,  -15447,  21845,
        0,          0,  65536
    };

    coeff_rec_t       awaited_coeffs [$];
    logic [CNT_W-1:0] filter_count;
    logic [CNT_W-1:0] channel_count;

    task automatic report_mismatch(input string what);
        if (mismatches < 40)
            $display("MISMATCH (transfer %0d): %s", coeffs_seen, what);
        mismatches++;
    endtask

    // Q.44 to Q.12, round half up, then saturate to 18 bits
    function automatic logic [COEFF_W-1:0] round_to_q12(input longint acc);
        longint r;
        r = (acc + 64'sd2147483648) >>> 32;
        if (r > 131071)
            r = 131071;
        if (r < -131072)
            r = -131072;
        return r[COEFF_W-1:0];
    endfunction

    // Work out all 36 coefficients of G*f*G^T with their addresses
    task automatic expect_tile(input logic [IN_DATA_W-1:0] d);
        longint     wt [9];
        longint     tm [18];
        longint     acc;
        longint     nf;
        longint     nc;
        longint     fi;
        longint     ci;
        longint     lin;
        logic       bad;
        coeff_rec_t rec;
        int         p;
        for (int k = 0; k < 9; k++)
            wt[k] = longint'($signed(d[16*k +: 16]));
        fi = d[153:144];
        ci = d[163:154];
        nf = (filter_count > MAX_FILTERS) ? MAX_FILTERS : filter_count;
        nc = (channel_count > MAX_CHANNELS) ? MAX_CHANNELS : channel_count;
        bad = (fi >= nf) || (ci >= nc);
        for (int i = 0; i < 6; i++)
            for (int j = 0; j < 3; j++)
            begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += GQ[i*3+k] * wt[k*3+j];
                tm[i*3+j] = acc;
            end
        for (int i = 0; i < 6; i++)
            for (int j = 0; j < 6; j++)
            begin
                p = i * 6 + j;
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += tm[i*3+k] * GQ[j*3+k];
                lin = p * nf * nc + ci * nf + fi;
                rec.pos   = p[5:0];
                rec.coeff = round_to_q12(acc);
                rec.addr  = bad ? '0 : lin[ADDR_W-1:0];
                rec.err   = bad;
                rec.last  = (p == 35);
                awaited_coeffs.push_back(rec);
            end
    endtask

    task automatic check_coeff();
        coeff_rec_t         want;
        logic [COEFF_W-1:0] got_coeff;
        logic [ADDR_W-1:0]  got_addr;
        got_coeff = m_tdata[COEFF_W-1:0];
        got_addr  = m_tdata[COEFF_W +: ADDR_W];
        if (awaited_coeffs.size() == 0)
            report_mismatch("coefficient transfer with nothing outstanding");
        else
        begin
            want = awaited_coeffs.pop_front();
            if (got_coeff !== want.coeff)
                report_mismatch($sformatf("pos %0d coeff %0d, want %0d", want.pos,
                    $signed(got_coeff), $signed(want.coeff)));
            if (got_addr !== want.addr)
                report_mismatch($sformatf("pos %0d address %0d, want %0d", want.pos,
                    got_addr, want.addr));
            if (m_tuser !== want.err)
                report_mismatch($sformatf("pos %0d index_error %b, want %b", want.pos,
                    m_tuser, want.err));
            if (m_tlast !== want.last)
                report_mismatch($sformatf("pos %0d tlast %b, want %b", want.pos,
                    m_tlast, want.last));
        end
        coeffs_seen++;
    endtask

    // Outputs first, then the new filter, then any register write
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_count  = 1;
            channel_count = 1;
            awaited_coeffs.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_coeff();
            if (s_tvalid && s_tready)
            begin
                expect_tile(s_tdata);
                filters_seen++;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_NUM_FILTERS:  filter_count  = cfg_data;
                    REG_NUM_CHANNELS: channel_count = cfg_data;
                    default: ;
                endcase
            end
        end
        pending = awaited_coeffs.size();
    end

endmodule

### tb/winograd_filter_transform_f4x4_3x3_top_test.sv
// Testbench top for the Winograd filter transform: clock, reset, stimulus and verdict.
module winograd_filter_transform_f4x4_3x3_top_test;
    import wft_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int GAP_MAX     = 14;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [0:0]            cfg_index;
    logic [CNT_W-1:0]      cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    // s_tdata: w00, w01, w02, w10, w11, w12, w20, w21, w22, filter_index, channel_index
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // m_tdata: coeff, dest_address
    logic [OUT_DATA_W-1:0] m_tdata;
    // m_tuser: index_error
    logic                  m_tuser;
    logic                  m_tlast;

    int chk_mismatches;
    int chk_pending;
    int chk_filters;
    int chk_coeffs;

    int               send_gap_max;
    int               recv_stall_max;
    int               hold_len;
    int               quiet_cycles;
    int               settings_used;
    logic [CNT_W-1:0] cur_nf;
    logic [CNT_W-1:0] cur_nc;

    winograd_filter_transform_f4x4_3x3_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    wft_coeff_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .mismatches   (chk_mismatches),
        .pending      (chk_pending),
        .filters_seen (chk_filters),
        .coeffs_seen  (chk_coeffs)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog: cycles with no transfer on either stream
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d coefficients outstanding",
                quiet_cycles, chk_pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Coefficient sink: random stalls per transfer, plus one long hold-off on request
    initial
    begin : coeff_sink
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_len > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold_len) @(negedge clk);
                hold_len = 0;
            end
            stall = $urandom_range(0, recv_stall_max);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            @(negedge clk);
        end
    end

    function automatic logic [15:0] rand_weight();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [NW*W_W-1:0] rand_tile();
        logic [NW*W_W-1:0] wts;
        for (int k = 0; k < NW; k++)
            wts[16*k +: 16] = rand_weight();
        return wts;
    endfunction

    // Mostly in range for the current count, now and then any index
    function automatic logic [IDX_W-1:0] pick_index(input logic [CNT_W-1:0] count);
        int lim;
        lim = (count > MAX_FILTERS) ? MAX_FILTERS : count;
        if (lim == 0 || $urandom_range(0, 9) == 0)
            return IDX_W'($urandom_range(0, 1023));
        return IDX_W'($urandom_range(0, lim - 1));
    endfunction

    // One filter transfer after a random gap; valid stays high into the next call
    task automatic send_filter(input logic [NW*W_W-1:0] wts, input logic [IDX_W-1:0] fi,
                               input logic [IDX_W-1:0] ci);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= {4'b0, ci, fi, wts};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    task automatic send_random(input int n);
        for (int i = 0; i < n; i++)
            send_filter(rand_tile(), pick_index(cur_nf), pick_index(cur_nc));
    endtask

    // Drop valid and let every outstanding coefficient come out
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (chk_pending != 0) @(negedge clk);
    endtask

    // Both counts, written back to back while the block is idle
    task automatic set_counts(input logic [CNT_W-1:0] nf, input logic [CNT_W-1:0] nc);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_NUM_FILTERS;
        cfg_data  <= nf;
        @(negedge clk);
        cfg_index <= REG_NUM_CHANNELS;
        cfg_data  <= nc;
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_nf = nf;
        cur_nc = nc;
        settings_used++;
    endtask

    task automatic run_phase(input logic [CNT_W-1:0] nf, input logic [CNT_W-1:0] nc,
                             input int n, input int gmax, input int smax);
        set_counts(nf, nc);
        send_gap_max   = gmax;
        recv_stall_max = smax;
        send_random(n);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_NUM_FILTERS;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        send_gap_max   = GAP_MAX;
        recv_stall_max = GAP_MAX;
        hold_len       = 0;
        quiet_cycles   = 0;
        settings_used  = 1;
        cur_nf         = 1;
        cur_nc         = 1;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset counts, weight extremes, impulse, indices off the end
        send_filter('0, 0, 0);
        send_filter({9{16'h7FFF}}, 0, 0);
        send_filter({9{16'h8000}}, 0, 0);
        send_filter({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                     16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 0, 0);
        send_filter({64'h0, 16'h1000, 64'h0}, 0, 0);
        send_filter(rand_tile(), 1, 0);
        send_filter(rand_tile(), 0, 1);
        send_filter(rand_tile(), 1023, 1023);

        // Full counts: largest address
        set_counts(1024, 1024);
        send_filter(rand_tile(), 1023, 1023);
        send_filter({9{16'h8000}}, 0, 0);
        send_filter(rand_tile(), 512, 1000);

        // Counts above the limit are clamped
        set_counts(2047, 2047);
        send_filter(rand_tile(), 1023, 1023);
        send_filter(rand_tile(), 0, 0);

        // Zero counts flag every index
        set_counts(0, 5);
        send_filter(rand_tile(), 0, 0);
        set_counts(5, 0);
        send_filter(rand_tile(), 0, 0);
        send_filter(rand_tile(), 4, 3);

        set_counts(1025, 1);
        send_filter(rand_tile(), 1023, 0);
        send_filter(rand_tile(), 1023, 1);

        set_counts(1, 1);
        send_filter(rand_tile(), 0, 0);

        // Random phases over a spread of counts and handshake timing
        run_phase(3, 7, 20, GAP_MAX, GAP_MAX);
        run_phase(1024, 1024, 20, 0, 0);

        // Sink holds off while the source keeps offering, so the input stalls
        set_counts(37, 20);
        send_gap_max   = 0;
        recv_stall_max = 3;
        hold_len       = 250;
        send_random(12);

        run_phase(1, 1024, 16, GAP_MAX, GAP_MAX);
        run_phase(1024, 1, 16, GAP_MAX, 0);
        run_phase(2047, 600, 16, 0, GAP_MAX);
        run_phase(100, 1025, 16, GAP_MAX, GAP_MAX);
        run_phase(CNT_W'($urandom_range(0, 2047)), CNT_W'($urandom_range(0, 2047)), 16,
                  GAP_MAX, GAP_MAX);
        run_phase(0, 0, 8, GAP_MAX, GAP_MAX);

        // Drain, then give any stray coefficient time to show up
        wait_idle();
        repeat (40) @(negedge clk);

        $display("covered %0d filters and %0d coefficient transfers over %0d count settings",
            chk_filters, chk_coeffs, settings_used);
        $display("with clamped, zero and out-of-range counts, stalls and a long sink hold-off");
        if (chk_mismatches == 0 && chk_pending == 0)
            $display("*** PASSED ***");
        else
        begin
            $display("%0d mismatches, %0d coefficients outstanding", chk_mismatches,
                chk_pending);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
